[sv/lfla_pkg.sv]
// ----------------------------------------------------------------------------
// Linked free-list allocator: shared package
// Types, constants and helper functions used by the allocator modules.
// ----------------------------------------------------------------------------
package lfla_pkg;

	// Size of the reference table and the width of an entry number.
	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int LINK_W  = IDX_W + 1;

	// The end mark terminates every list and is the value for "no entry".
	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(ENTRIES);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);

	// Reset value of the reserved-entries register.
	localparam logic [IDX_W-1:0] RESERVED_RST = IDX_W'(8);

	// Command codes.
	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_ALLOC   = 3'd1,
		CMD_FREE    = 3'd2,
		CMD_FREE_CH = 3'd3,
		CMD_CLAIM   = 3'd4,
		CMD_RELEASE = 3'd5
	} cmd_t;

	// One command as it enters the controller.
	typedef struct packed {
		cmd_t              command;
		logic [LINK_W-1:0] count;
		logic [IDX_W-1:0]  ref_req;
		logic [LINK_W-1:0] own_head;
	} req_t;

	// One result as it leaves the controller.
	typedef struct packed {
		logic              status;
		logic [LINK_W-1:0] ref_out;
		logic [LINK_W-1:0] new_own_head;
		logic [LINK_W-1:0] free_count;
	} result_t;

	// Limit a link value to the end mark.
	function automatic logic [LINK_W-1:0] clip_link(input logic [LINK_W-1:0] v);
		return (v >= END_MARK) ? END_MARK : v;
	endfunction

	// Add to the free count, saturating at the table size.
	function automatic logic [LINK_W-1:0] add_sat(input logic [LINK_W-1:0] a,
		input logic [LINK_W-1:0] b);
		logic [LINK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, END_MARK}) ? END_MARK : s[LINK_W-1:0];
	endfunction

endpackage

[sv/lfla_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read. A read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module lfla_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/lfla_ctrl.sv]
// ----------------------------------------------------------------------------
// Linked free-list allocator: command sequencer
// Holds the free head and free count, walks links in the link memory one
// read per cycle and writes back the updated links.
// ----------------------------------------------------------------------------
module lfla_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfla_pkg::req_t                req,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [lfla_pkg::IDX_W-1:0]    reserved,
	output lfla_pkg::result_t             res,
	output logic                          res_valid,
	input  logic                          res_ready
);
	import lfla_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_WALK  = 6'b000100,
		ST_CHAIN = 6'b001000,
		ST_CLAIM = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] total_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] left_q;
	logic [LINK_W-1:0] n_q;
	logic [IDX_W-1:0]  ridx_q;
	logic [IDX_W-1:0]  rq_q;
	logic              rd_end_q;
	logic              res_status_q;
	logic [LINK_W-1:0] res_ref_q;
	logic [LINK_W-1:0] res_nph_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [LINK_W-1:0] ram_rdata;
	logic [LINK_W-1:0] link_val;
	logic              accept;
	logic              chain_more;

	lfla_ram #(
		.WIDTH(LINK_W),
		.DEPTH(ENTRIES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign res_valid = (state_q == ST_DONE);

	// A link read at the end mark yields the end mark without a memory access.
	assign link_val   = rd_end_q ? END_MARK : clip_link(ram_rdata);
	assign chain_more = (n_q < END_MARK) && (link_val != END_MARK);

	always_comb begin
		res.status       = res_status_q;
		res.ref_out      = res_ref_q;
		res.new_own_head = res_nph_q;
		res.free_count   = total_q;
	end

	// Link memory addressing. A read issued in the cycle of a write is never
	// used, so no forwarding path is needed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q[IDX_W-1:0];
		ram_wdata = END_MARK;
		ram_raddr = link_val[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				unique case (req.command)
					CMD_ALLOC:   ram_raddr = head_q[IDX_W-1:0];
					CMD_FREE_CH: ram_raddr = req.ref_req;
					CMD_CLAIM:   ram_raddr = req.own_head[IDX_W-1:0];
					CMD_FREE: begin
						ram_we    = accept;
						ram_waddr = req.ref_req;
						ram_wdata = head_q;
					end
					CMD_RELEASE: begin
						ram_we    = accept;
						ram_waddr = req.ref_req;
						ram_wdata = clip_link(req.own_head);
					end
					default: ;
				endcase
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = ridx_q;
				ram_wdata = {1'b0, ridx_q} + LINK_W'(1);
			end
			ST_WALK: begin
				ram_we = (left_q == '0) && !rd_end_q;
			end
			ST_CHAIN: begin
				ram_we    = !chain_more;
				ram_wdata = head_q;
			end
			ST_CLAIM, ST_DONE: ;
			default: ;
		endcase
	end

	// Sequencer and allocator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= END_MARK;
			total_q      <= '0;
			cur_q        <= END_MARK;
			left_q       <= '0;
			n_q          <= '0;
			ridx_q       <= '0;
			rq_q         <= '0;
			rd_end_q     <= 1'b0;
			res_status_q <= 1'b0;
			res_ref_q    <= END_MARK;
			res_nph_q    <= END_MARK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_status_q <= 1'b0;
						res_ref_q    <= END_MARK;
						res_nph_q    <= END_MARK;
						rq_q         <= req.ref_req;
						rd_end_q     <= 1'b0;
						state_q      <= ST_DONE;
						unique case (req.command)
							CMD_INIT: begin
								ridx_q  <= reserved;
								head_q  <= {1'b0, reserved};
								total_q <= END_MARK - {1'b0, reserved};
								state_q <= ST_INIT;
							end
							CMD_ALLOC: begin
								if (req.count == '0 || req.count > total_q) begin
									res_status_q <= 1'b1;
								end else begin
									res_ref_q <= head_q;
									total_q   <= total_q - req.count;
									cur_q     <= head_q;
									rd_end_q  <= (head_q == END_MARK);
									left_q    <= req.count - LINK_W'(1);
									state_q   <= ST_WALK;
								end
							end
							CMD_FREE: begin
								head_q  <= {1'b0, req.ref_req};
								total_q <= add_sat(total_q, LINK_W'(1));
							end
							CMD_FREE_CH: begin
								cur_q   <= {1'b0, req.ref_req};
								n_q     <= LINK_W'(1);
								state_q <= ST_CHAIN;
							end
							CMD_CLAIM: begin
								if (req.own_head >= END_MARK) begin
									res_status_q <= 1'b1;
								end else begin
									res_ref_q <= req.own_head;
									state_q   <= ST_CLAIM;
								end
							end
							CMD_RELEASE: begin
								res_nph_q <= {1'b0, req.ref_req};
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					ridx_q <= ridx_q + IDX_W'(1);
					if (ridx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_WALK: begin
					if (left_q == '0) begin
						head_q  <= link_val;
						state_q <= ST_DONE;
					end else begin
						cur_q    <= link_val;
						rd_end_q <= (link_val == END_MARK);
						left_q   <= left_q - LINK_W'(1);
					end
				end
				ST_CHAIN: begin
					if (chain_more) begin
						cur_q <= link_val;
						n_q   <= n_q + LINK_W'(1);
					end else begin
						head_q  <= {1'b0, rq_q};
						total_q <= add_sat(total_q, n_q);
						state_q <= ST_DONE;
					end
				end
				ST_CLAIM: begin
					res_nph_q <= link_val;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The free count never exceeds the table size.
	assert property (@(posedge clk) disable iff (!arst_n) total_q <= END_MARK)
		else $error("free count above table size");

	// Each walk step consumes exactly one of the remaining reads.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && left_q != '0) |=>
		(state_q == ST_WALK && left_q == $past(left_q) - LINK_W'(1)))
		else $error("allocation walk lost a step");

	// A chain walk never counts more entries than the table holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHAIN) |-> (n_q != '0 && n_q <= END_MARK))
		else $error("chain length out of range");

	// An accepted command always leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted command did not start");

endmodule

[sv/linked_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Linked free-list allocator: top level
// Keeps the free entries of a 1024-entry reference table as a linked list
// in a link memory; allocates and frees chains and single entries.
// ----------------------------------------------------------------------------
// One command is in progress at a time; the next is accepted only after
// the result has entered the output register. The link walks are bound
// by the one read port of the link memory.
// Reset clears the free list (empty head, count 0) and sets reserved_entries
// to 8; the link memory is not cleared and must be initialised by command.
// ----------------------------------------------------------------------------
module linked_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // count[10:0], ref_req[20:11], own_head[31:21]
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // ref_out[10:0], new_own_head[21:11],
	                               // free_count[32:22], zero fill[39:33]
	output logic        m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data   // reserved_entries
);
	import lfla_pkg::*;

	req_t             req;
	result_t          res;
	logic             res_valid;
	logic             res_ready;
	logic [IDX_W-1:0] reserved_q;
	result_t          out_q;
	logic             out_valid_q;

	// Unpack the incoming command.
	always_comb begin
		req.command  = cmd_t'(s_tuser);
		req.count    = s_tdata[10:0];
		req.ref_req  = s_tdata[20:11];
		req.own_head = s_tdata[31:21];
	end

	lfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.reserved (reserved_q),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= RESERVED_RST;
		end else if (cfg_valid && cfg_ready) begin
			reserved_q <= cfg_data;
		end
	end

	// Output register: takes a result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {7'b0, out_q.free_count, out_q.new_own_head, out_q.ref_out};

endmodule

[verif/lfla_result_check.sv]
// ----------------------------------------------------------------------------
// Linked free-list allocator: result checker
// Watches the command, result and register channels of the allocator. It keeps
// its own copy of the link table, the free list and the reserved count, works
// out the result of every accepted command, and compares each accepted result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lfla_result_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // count[10:0], ref_req[20:11], own_head[31:21]
	input  logic [2:0]  s_tuser,   // command[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // ref_out[10:0], new_own_head[21:11],
	                               // free_count[32:22], zero fill[39:33]
	input  logic        m_tuser,   // status
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [9:0]  cfg_data,  // reserved_entries
	output int          mismatches,
	output int          awaiting
);
	import lfla_pkg::*;

	// Shadow of the allocator state.
	logic [LINK_W-1:0] links [ENTRIES];
	logic [LINK_W-1:0] head_entry;
	logic [LINK_W-1:0] free_entries;
	logic [IDX_W-1:0]  reserved;

	// Predicted results, oldest first.
	result_t predicted_results[$];

	// Read a link; anything at or past the end mark reads as the end mark.
	function automatic logic [LINK_W-1:0] link_of(input logic [LINK_W-1:0] e);
		return (e >= END_MARK) ? END_MARK : links[e[IDX_W-1:0]];
	endfunction

	// Write a link, limiting the stored value to the end mark.
	task automatic set_link(input int e, input int v);
		if (e < ENTRIES)
			links[e] = (v >= ENTRIES) ? END_MARK : LINK_W'(v);
	endtask

	// Grow the free count, saturating at the table size.
	task automatic grow_free(input int n);
		free_entries = (int'(free_entries) + n > ENTRIES) ? END_MARK :
			LINK_W'(int'(free_entries) + n);
	endtask

	// Apply one command to the shadow state and work out its result.
	task automatic predict_outcome(input logic [2:0] op, input logic [LINK_W-1:0] cnt,
		input logic [IDX_W-1:0] rq, input logic [LINK_W-1:0] ph, output result_t r);
		logic [LINK_W-1:0] cur;
		int n;
		r.status       = 1'b0;
		r.ref_out      = END_MARK;
		r.new_own_head = END_MARK;
		case (op)
			CMD_INIT: begin
				for (n = int'(reserved); n < ENTRIES; n++)
					set_link(n, n + 1);
				head_entry   = LINK_W'(reserved);
				free_entries = LINK_W'(ENTRIES - int'(reserved));
			end
			CMD_ALLOC: begin
				if (cnt == 0 || cnt > free_entries) begin
					r.status = 1'b1;
				end else begin
					r.ref_out    = head_entry;
					cur          = head_entry;
					free_entries = free_entries - cnt;
					for (n = 1; n < int'(cnt); n++)
						cur = link_of(cur);
					head_entry = link_of(cur);
					set_link(cur, ENTRIES);
				end
			end
			CMD_FREE: begin
				set_link(rq, head_entry);
				head_entry = {1'b0, rq};
				grow_free(1);
			end
			CMD_FREE_CH: begin
				// Walk to the tail; a cyclic chain stops after a full table.
				cur = {1'b0, rq};
				n   = 1;
				while (n < ENTRIES && link_of(cur) != END_MARK) begin
					cur = link_of(cur);
					n++;
				end
				set_link(cur, head_entry);
				head_entry = {1'b0, rq};
				grow_free(n);
			end
			CMD_CLAIM: begin
				if (ph >= END_MARK) begin
					r.status = 1'b1;
				end else begin
					r.ref_out      = ph;
					r.new_own_head = link_of(ph);
				end
			end
			CMD_RELEASE: begin
				set_link(rq, ph);
				r.new_own_head = {1'b0, rq};
			end
			default: begin
			end
		endcase
		r.free_count = free_entries;
	endtask

	// Report one field that differs from its prediction.
	task automatic check_field(input string label, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	// Register writes, then new commands, then finished results.
	always @(posedge clk or negedge arst_n) begin
		result_t forecast;
		result_t oldest;
		if (!arst_n) begin
			head_entry   = END_MARK;
			free_entries = '0;
			reserved     = RESERVED_RST;
			predicted_results.delete();
			mismatches   = 0;
			awaiting     = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reserved = cfg_data;
			if (s_tvalid && s_tready) begin
				predict_outcome(s_tuser, s_tdata[10:0], s_tdata[20:11], s_tdata[31:21],
					forecast);
				predicted_results.push_back(forecast);
			end
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result transaction with nothing expected: status %0d, ref %0d",
						$time, m_tuser, m_tdata[10:0]);
					mismatches++;
				end else begin
					oldest = predicted_results.pop_front();
					check_field("status", oldest.status, m_tuser);
					check_field("ref_out", oldest.ref_out, m_tdata[10:0]);
					check_field("new_own_head", oldest.new_own_head, m_tdata[21:11]);
					check_field("free_count", oldest.free_count, m_tdata[32:22]);
				end
			end
			awaiting = predicted_results.size();
		end
	end

endmodule

[verif/linked_free_list_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Linked free-list allocator: testbench top
// Drives commands and register writes into the allocator with random gaps and
// output stalls. A directed part covers refusals, full-table chains, overflow
// of the free count, cyclic chains and the reserved-count extremes; three
// random phases follow, mostly allocating chains and handing the returned
// entries back. The result checker beside the block reports every mismatch.
// ----------------------------------------------------------------------------
module linked_free_list_allocator_tb;
	import lfla_pkg::*;

	// Command codes the block does not define; they must leave it unchanged.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 20000;
	localparam int POOL_DEPTH   = 64;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [9:0]  cfg_data;

	int mismatches;
	int awaiting;
	int send_gap_pct;
	int take_gap_pct;
	int hold_requests;
	int quiet_cycles = 0;

	// Entries handed out by the block, kept for later frees, claims and releases.
	logic [LINK_W-1:0] chain_heads[$];
	logic [LINK_W-1:0] own_heads[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	linked_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lfla_result_check results_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// Collect returned entries so that later commands work on real chains.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tdata[10:0] != END_MARK)
				chain_heads.push_back(m_tdata[10:0]);
			if (m_tdata[21:11] != END_MARK)
				own_heads.push_back(m_tdata[21:11]);
			if (chain_heads.size() > POOL_DEPTH)
				void'(chain_heads.pop_front());
			if (own_heads.size() > POOL_DEPTH)
				void'(own_heads.pop_front());
		end
	end

	// Pick a collected entry, preferring own heads where asked; random if none.
	function automatic logic [LINK_W-1:0] pool_pick(input bit private_side);
		if (private_side && own_heads.size() > 0)
			return own_heads[$urandom_range(0, own_heads.size() - 1)];
		if (chain_heads.size() > 0)
			return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
		return LINK_W'($urandom_range(0, ENTRIES - 1));
	endfunction

	// Result receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		int hold_left;
		int holds_taken;
		hold_left   = 0;
		holds_taken = 0;
		m_tready    = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_taken) begin
				holds_taken = hold_requests;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	// Watchdog: end the run if no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one command, with random idle cycles first; returns on a falling edge.
	task automatic send_cmd(input logic [2:0] op, input logic [LINK_W-1:0] cnt,
		input logic [IDX_W-1:0] rq, input logic [LINK_W-1:0] ph);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ph, rq, cnt};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has arrived.
	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the reserved count while the block is idle.
	task automatic write_reserved(input logic [IDX_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random command, mostly allocations and returns of earlier entries.
	task automatic random_cmd;
		int pick;
		int sel;
		logic [2:0]        op;
		logic [LINK_W-1:0] cnt;
		logic [IDX_W-1:0]  rq;
		logic [LINK_W-1:0] ph;
		pick = $urandom_range(99);
		sel  = $urandom_range(99);
		cnt  = LINK_W'($urandom_range(0, ENTRIES));
		rq   = IDX_W'($urandom_range(0, ENTRIES - 1));
		ph   = LINK_W'($urandom_range(0, ENTRIES));
		if (pick < 30) begin
			op = CMD_ALLOC;
			if (sel < 70)
				cnt = LINK_W'($urandom_range(1, 8));
			else if (sel < 93)
				cnt = LINK_W'($urandom_range(9, 64));
			else if (sel < 96)
				cnt = LINK_W'($urandom_range(65, ENTRIES));
			else if (sel < 98)
				cnt = '0;
			else
				cnt = END_MARK;
		end else if (pick < 50) begin
			op = CMD_FREE_CH;
			rq = IDX_W'(pool_pick(1'b0));
		end else if (pick < 63) begin
			op = CMD_FREE;
			rq = IDX_W'(pool_pick(1'b0));
		end else if (pick < 78) begin
			op = CMD_CLAIM;
			ph = (sel < 15) ? END_MARK : pool_pick(1'b1);
		end else if (pick < 93) begin
			op = CMD_RELEASE;
			rq = IDX_W'(pool_pick(1'b0));
			ph = (sel < 20) ? END_MARK : pool_pick(1'b1);
		end else if (pick < 96) begin
			op = CMD_INIT;
		end else begin
			op = (sel < 50) ? CMD_SPARE_A : CMD_SPARE_B;
		end
		send_cmd(op, cnt, rq, ph);
	endtask

	// Main stimulus sequence.
	initial begin
		int phase;
		int item;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		send_gap_pct  = 0;
		take_gap_pct  = 0;
		hold_requests = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Before any initialisation only written links may be read.
		send_cmd(CMD_ALLOC, 11'd0, 10'd0, END_MARK);
		send_cmd(CMD_ALLOC, 11'd5, 10'd0, END_MARK);
		send_cmd(CMD_CLAIM, 11'd0, 10'd0, END_MARK);
		send_cmd(CMD_RELEASE, 11'd0, 10'd3, END_MARK);
		send_cmd(CMD_FREE, 11'd0, LAST_IDX, END_MARK);
		send_cmd(CMD_CLAIM, 11'd0, 10'd0, 11'd3);
		send_cmd(CMD_SPARE_A, END_MARK, LAST_IDX, 11'd1023);
		send_cmd(CMD_SPARE_B, 11'd0, 10'd0, 11'd0);
		send_cmd(CMD_INIT, 11'd0, 10'd0, 11'd0);

		// With nothing reserved the whole table is linked and can be read freely.
		write_reserved(10'd0);
		send_cmd(CMD_INIT, 11'd0, 10'd0, 11'd0);
		send_cmd(CMD_ALLOC, END_MARK, 10'd0, 11'd0);
		send_cmd(CMD_ALLOC, 11'd1, 10'd0, 11'd0);
		send_cmd(CMD_FREE_CH, 11'd0, 10'd0, 11'd0);
		// Freeing into a full list saturates the count and closes a loop.
		send_cmd(CMD_FREE, 11'd0, LAST_IDX, 11'd0);
		send_cmd(CMD_FREE_CH, 11'd0, LAST_IDX, 11'd0);
		send_cmd(CMD_ALLOC, 11'd1023, 10'd682, 11'd341);
		send_cmd(CMD_CLAIM, 11'd0, 10'd0, 11'd1023);
		send_cmd(CMD_RELEASE, 11'd0, LAST_IDX, END_MARK);
		send_cmd(CMD_RELEASE, 11'd0, 10'd0, 11'd1023);

		// Largest reserved count leaves a single free entry.
		write_reserved(LAST_IDX);
		send_cmd(CMD_INIT, 11'd0, 10'd0, 11'd0);
		send_cmd(CMD_ALLOC, 11'd1, 10'd0, 11'd0);
		send_cmd(CMD_ALLOC, 11'd1, 10'd0, 11'd0);
		send_cmd(CMD_FREE, 11'd0, LAST_IDX, 11'd0);

		// Random phases: receiver mostly idle, sender mostly idle, then neither.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: write_reserved(IDX_W'($urandom_range(1, 64)));
				1: write_reserved(IDX_W'($urandom_range(65, 700)));
				default: write_reserved(RESERVED_RST);
			endcase
			send_gap_pct = (phase == 0) ? 29 : (phase == 1) ? 79 : 0;
			take_gap_pct = (phase == 0) ? 79 : (phase == 1) ? 29 : 0;
			send_cmd(CMD_INIT, 11'd0, 10'd0, 11'd0);
			for (item = 0; item < PHASE_ITEMS; item++) begin
				if (phase == 2 && item == PHASE_ITEMS / 4)
					hold_requests++;
				random_cmd();
			end
		end

		drain_results();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
